// ===== src/escape_string_unquoter_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the escape string unquoter
// Concurrent checks clocked by clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef ESCAPE_STRING_UNQUOTER_DEFINES_SVH
`define ESCAPE_STRING_UNQUOTER_DEFINES_SVH

`ifndef SYNTH
`define ESU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("escape_string_unquoter: check failed");
`define ESU_NEVER(label, expr) \
  `ESU_ASSERT(label, !(expr))
`else
`define ESU_ASSERT(label, prop)
`define ESU_NEVER(label, expr)
`endif

`endif

// ===== src/esu_pkg.sv =====
// ---------------------------------------------------------------------------
// esu_pkg
// Types, character codes and helper functions shared by the unquoter.
// ---------------------------------------------------------------------------
`default_nettype none

package esu_pkg;

  localparam int MAX_RES     = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_ESC = 8'h1B;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_ESC  = 6'b000010,
    PH_HEX1 = 6'b000100,
    PH_HEX2 = 6'b001000,
    PH_OCT1 = 6'b010000,
    PH_OCT2 = 6'b100000
  } phase_t;

  // One request's worth of output bytes, byte 0 goes out first.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic logic is_char(input logic [20:0] c, input logic [7:0] ch);
    return c == {13'd0, ch};
  endfunction

  function automatic logic is_oct(input logic [20:0] c);
    return c >= 21'h30 && c <= 21'h37;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [20:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 21'h30 && c <= 21'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] c);
    utf8_t u;
    u = '0;
    if ((c >= 21'h00D800 && c <= 21'h00DFFF) || c > 21'h10FFFF) begin
      u.b[0] = 8'hEF;
      u.b[1] = 8'hBF;
      u.b[2] = 8'hBD;
      u.n    = 3'd3;
    end else if (c < 21'h80) begin
      u.b[0] = c[7:0];
      u.n    = 3'd1;
    end else if (c < 21'h800) begin
      u.b[0] = {3'b110, c[10:6]};
      u.b[1] = {2'b10, c[5:0]};
      u.n    = 3'd2;
    end else if (c < 21'h10000) begin
      u.b[0] = {4'b1110, c[15:12]};
      u.b[1] = {2'b10, c[11:6]};
      u.b[2] = {2'b10, c[5:0]};
      u.n    = 3'd3;
    end else begin
      u.b[0] = {5'b11110, c[20:18]};
      u.b[1] = {2'b10, c[17:12]};
      u.b[2] = {2'b10, c[11:6]};
      u.b[3] = {2'b10, c[5:0]};
      u.n    = 3'd4;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/esu_front.sv =====
// ---------------------------------------------------------------------------
// esu_front
// Takes code points, tracks the escape phase and packs each request's bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module esu_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [20:0]         code_point,
  input  wire logic                is_last,
  input  wire esu_pkg::q_status_t  q_stat,
  output logic                     push,
  output esu_pkg::entry_t          push_entry
);

  esu_pkg::phase_t phase, phase_next;
  logic [7:0]      pending, pending_next;

  logic            accept;
  logic [1:0][7:0] pre;
  logic [1:0]      pre_cnt;
  logic            do_plain;
  logic            plain_bsl;
  logic [4:0]      hv;
  logic [5:0]      oct_v;
  esu_pkg::utf8_t  utf;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign hv       = esu_pkg::hex_digit(code_point);
  assign oct_v    = {pending[2:0], code_point[2:0]};

  always_comb begin
    phase_next   = esu_pkg::PH_IDLE;
    pending_next = pending;
    pre          = '0;
    pre_cnt      = 2'd0;
    do_plain     = 1'b0;
    unique case (phase)
      esu_pkg::PH_ESC: begin
        if (esu_pkg::is_char(code_point, esu_pkg::CH_BSL) ||
            esu_pkg::is_char(code_point, esu_pkg::CH_DQ) ||
            esu_pkg::is_char(code_point, esu_pkg::CH_SQ)) begin
          pre[0] = code_point[7:0];  pre_cnt = 2'd1;
        end else if (esu_pkg::is_char(code_point, esu_pkg::CH_N)) begin
          pre[0] = esu_pkg::BYTE_LF;  pre_cnt = 2'd1;
        end else if (esu_pkg::is_char(code_point, esu_pkg::CH_R)) begin
          pre[0] = esu_pkg::BYTE_CR;  pre_cnt = 2'd1;
        end else if (esu_pkg::is_char(code_point, esu_pkg::CH_T)) begin
          pre[0] = esu_pkg::BYTE_TAB; pre_cnt = 2'd1;
        end else if (esu_pkg::is_char(code_point, esu_pkg::CH_E)) begin
          pre[0] = esu_pkg::BYTE_ESC; pre_cnt = 2'd1;
        end else if (esu_pkg::is_char(code_point, esu_pkg::CH_X)) begin
          if (is_last) begin
            pre[0] = esu_pkg::CH_BSL; pre[1] = esu_pkg::CH_X; pre_cnt = 2'd2;
          end else begin
            phase_next = esu_pkg::PH_HEX1;
          end
        end else if (esu_pkg::is_oct(code_point)) begin
          if (is_last) begin
            pre[0] = {5'd0, code_point[2:0]}; pre_cnt = 2'd1;
          end else begin
            pending_next = {5'd0, code_point[2:0]};
            phase_next   = esu_pkg::PH_OCT1;
          end
        end else begin
          // unknown escape: backslash, then the char again as text
          pre[0] = esu_pkg::CH_BSL; pre_cnt = 2'd1;
          do_plain = 1'b1;
        end
      end
      esu_pkg::PH_HEX1: begin
        if (hv[4]) begin
          if (is_last) begin
            pre[0] = {4'd0, hv[3:0]}; pre_cnt = 2'd1;
          end else begin
            pending_next = {4'd0, hv[3:0]};
            phase_next   = esu_pkg::PH_HEX2;
          end
        end else begin
          pre[0] = esu_pkg::CH_BSL; pre[1] = esu_pkg::CH_X; pre_cnt = 2'd2;
          do_plain = 1'b1;
        end
      end
      esu_pkg::PH_HEX2: begin
        pre_cnt = 2'd1;
        if (hv[4]) begin
          pre[0] = {pending[3:0], hv[3:0]};
        end else begin
          pre[0] = pending;
          do_plain = 1'b1;
        end
      end
      esu_pkg::PH_OCT1: begin
        if (esu_pkg::is_oct(code_point)) begin
          if (is_last) begin
            pre[0] = {2'd0, oct_v}; pre_cnt = 2'd1;
          end else begin
            pending_next = {2'd0, oct_v};
            phase_next   = esu_pkg::PH_OCT2;
          end
        end else begin
          pre[0] = pending; pre_cnt = 2'd1;
          do_plain = 1'b1;
        end
      end
      esu_pkg::PH_OCT2: begin
        pre_cnt = 2'd1;
        if (esu_pkg::is_oct(code_point)) begin
          pre[0] = {pending[4:0], code_point[2:0]};
        end else begin
          pre[0] = pending;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // a backslash in text opens an escape unless the string ends here
    plain_bsl = do_plain && esu_pkg::is_char(code_point, esu_pkg::CH_BSL) && !is_last;
    if (plain_bsl) begin
      phase_next = esu_pkg::PH_ESC;
    end
    if (phase_next == esu_pkg::PH_IDLE || is_last) begin
      phase_next   = esu_pkg::PH_IDLE;
      pending_next = 8'd0;
    end
  end

  always_comb begin
    utf = esu_pkg::utf8_encode(code_point);
    if (!do_plain || plain_bsl) begin
      utf = '0;
    end
    push_entry.last = is_last;
    push_entry.cnt  = {1'b0, pre_cnt} + utf.n;
    case (pre_cnt)
      2'd0:    push_entry.bytes = {16'd0, utf.b};
      2'd1:    push_entry.bytes = {8'd0, utf.b, pre[0]};
      default: push_entry.bytes = {utf.b, pre[1], pre[0]};
    endcase
  end

  assign push = accept && (push_entry.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= esu_pkg::PH_IDLE;
      pending <= 8'd0;
    end else if (accept) begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/esu_queue.sv =====
// ---------------------------------------------------------------------------
// esu_queue
// Small register queue of packed byte groups between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module esu_queue #(
  parameter int DEPTH = esu_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire esu_pkg::entry_t     push_entry,
  input  wire logic                pop,
  output esu_pkg::entry_t          head,
  output esu_pkg::q_status_t       q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esu_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign q_stat.empty = (count == CW'(0));
  assign q_stat.full  = (count == CW'(DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/esu_back.sv =====
// ---------------------------------------------------------------------------
// esu_back
// Walks head bytes one per cycle into the output register unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module esu_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire esu_pkg::entry_t     head,
  input  wire esu_pkg::q_status_t  q_stat,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     run_last,
  output logic                     string_end
);

  logic [2:0] bidx;
  logic       load, take, fin;

  assign load = !out_valid || !out_stall;
  assign take = load && !q_stat.empty;
  assign fin  = (bidx + 3'd1) == head.cnt;
  assign pop  = take && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bidx      <= 3'd0;
    end else if (load) begin
      out_valid <= take;
      if (take) begin
        bidx <= fin ? 3'd0 : bidx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= head.bytes[bidx];
      run_last   <= fin;
      string_end <= fin && head.last;
    end
  end

endmodule

`default_nettype wire

// ===== src/escape_string_unquoter.sv =====
// Path: accepted bytes are written to the queue, then to the output register.
// Throughput: one code point per cycle while each gives at most one byte and nothing
// stalls; the output sends one byte per cycle, and a multi-byte group holds it longer.
// The byte-group queue (QUEUE_DEPTH entries) lets input run ahead of a stalled output.
// Reset: escape phase idle, pending value zero, queue empty, out_valid low.
// ---------------------------------------------------------------------------
// escape_string_unquoter
// Decodes backslash escapes in a code point stream and emits UTF-8 bytes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "escape_string_unquoter_defines.svh"

module escape_string_unquoter #(
  parameter int QUEUE_DEPTH = esu_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [20:0] code_point,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             string_end
);

  esu_pkg::q_status_t q_stat;
  esu_pkg::entry_t    push_entry, head;
  logic               q_push, q_pop;

  esu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .is_last    (is_last),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (push_entry)
  );

  esu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  esu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

  // string end always closes a request's byte run
  `ESU_ASSERT(a_end_has_run_last, out_valid && string_end |-> run_last)
  // nothing leaves an empty queue
  `ESU_NEVER(a_no_pop_empty, q_pop && q_stat.empty)
  // a request is only popped while the output can take a byte
  `ESU_ASSERT(a_pop_loads_out, q_pop |=> out_valid)

endmodule

`default_nettype wire
